// ----- rtl/tbt_pkg.sv -----
// shared constants and types for the triangle barycentric test core
`timescale 1ns / 1ps
package tbt_pkg;

   localparam int COORD_FRAC_BITS = 14;
   localparam int COORD_W         = 18;
   localparam int WEIGHT_W        = 18;
   localparam int DIFF_W          = COORD_W + 1;
   localparam int PROD_W          = 2 * DIFF_W;
   localparam int CROSS_W         = PROD_W + 1;
   localparam int MAG_W           = CROSS_W - 1;
   localparam int NUM_W           = MAG_W + COORD_FRAC_BITS + 1;
   localparam int SGN_W           = NUM_W + 1;
   localparam int U_W             = SGN_W + 2;
   localparam int FRONT_STAGES    = 5;
   localparam int BACK_STAGES     = 2;
   localparam int LATENCY         = FRONT_STAGES + NUM_W + BACK_STAGES;

   typedef struct packed {
      logic in_tri;
      logic degen;
      logic neg_v;
      logic neg_w;
   } tag_type;

   // one divider cell's worth of data: two lanes sharing a divisor
   typedef struct packed {
      logic [MAG_W-1:0] rem_v;
      logic [MAG_W-1:0] rem_w;
      logic [NUM_W-1:0] quo_v;
      logic [NUM_W-1:0] quo_w;
      logic [MAG_W-1:0] den;
      tag_type          tag;
   } div_type;

endpackage

// ----- rtl/tbt_front.sv -----
// edge vectors, cross products, sign tests and dividend set-up
`timescale 1ns / 1ps
module tbt_front
   import tbt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] point_u,
   input  logic signed [COORD_W-1:0] point_v,
   input  logic signed [COORD_W-1:0] vert_a_u,
   input  logic signed [COORD_W-1:0] vert_a_v,
   input  logic signed [COORD_W-1:0] vert_b_u,
   input  logic signed [COORD_W-1:0] vert_b_v,
   input  logic signed [COORD_W-1:0] vert_c_u,
   input  logic signed [COORD_W-1:0] vert_c_v,
   output logic                      out_valid,
   output div_type                   out_data
);

   logic [FRONT_STAGES-1:0] valid_ff, valid_in;

   // stage 1: differences
   logic signed [DIFF_W-1:0] e0u_ff, e0v_ff, e1u_ff, e1v_ff, e2u_ff, e2v_ff;
   logic signed [DIFF_W-1:0] cbu_ff, cbv_ff, pbu_ff, pbv_ff;
   // stage 2: products
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff, p7_ff;
   // stage 3: cross products
   logic signed [CROSS_W-1:0] wn_ff, an_ff, bc_ff, dd_ff;
   // stage 4: magnitudes and flags
   logic [MAG_W-1:0] mag_v_ff, mag_w_ff, mag_d_ff;
   tag_type          tag4_ff, tag4_in;
   // stage 5: rounded dividends
   div_type          div_ff, div_in;

   assign valid_in = {valid_ff[FRONT_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e0u_ff <= DIFF_W'(vert_b_u) - DIFF_W'(vert_a_u);
      e0v_ff <= DIFF_W'(vert_b_v) - DIFF_W'(vert_a_v);
      e1u_ff <= DIFF_W'(vert_c_u) - DIFF_W'(vert_a_u);
      e1v_ff <= DIFF_W'(vert_c_v) - DIFF_W'(vert_a_v);
      e2u_ff <= DIFF_W'(point_u) - DIFF_W'(vert_a_u);
      e2v_ff <= DIFF_W'(point_v) - DIFF_W'(vert_a_v);
      cbu_ff <= DIFF_W'(vert_c_u) - DIFF_W'(vert_b_u);
      cbv_ff <= DIFF_W'(vert_c_v) - DIFF_W'(vert_b_v);
      pbu_ff <= DIFF_W'(point_u) - DIFF_W'(vert_b_u);
      pbv_ff <= DIFF_W'(point_v) - DIFF_W'(vert_b_v);

      p0_ff <= PROD_W'(e0u_ff) * PROD_W'(e2v_ff);
      p1_ff <= PROD_W'(e0v_ff) * PROD_W'(e2u_ff);
      p2_ff <= PROD_W'(e1u_ff) * PROD_W'(e2v_ff);
      p3_ff <= PROD_W'(e1v_ff) * PROD_W'(e2u_ff);
      p4_ff <= PROD_W'(cbu_ff) * PROD_W'(pbv_ff);
      p5_ff <= PROD_W'(cbv_ff) * PROD_W'(pbu_ff);
      p6_ff <= PROD_W'(e0u_ff) * PROD_W'(e1v_ff);
      p7_ff <= PROD_W'(e0v_ff) * PROD_W'(e1u_ff);

      // an is cross(e1, e2), the negated v numerator
      wn_ff <= CROSS_W'(p0_ff) - CROSS_W'(p1_ff);
      an_ff <= CROSS_W'(p2_ff) - CROSS_W'(p3_ff);
      bc_ff <= CROSS_W'(p4_ff) - CROSS_W'(p5_ff);
      dd_ff <= CROSS_W'(p6_ff) - CROSS_W'(p7_ff);

      mag_v_ff <= an_ff[CROSS_W-1] ? MAG_W'(-an_ff) : MAG_W'(an_ff);
      mag_w_ff <= wn_ff[CROSS_W-1] ? MAG_W'(-wn_ff) : MAG_W'(wn_ff);
      mag_d_ff <= dd_ff[CROSS_W-1] ? MAG_W'(-dd_ff) : MAG_W'(dd_ff);
      tag4_ff  <= tag4_in;

      div_ff   <= div_in;
   end

   always_comb begin
      logic s_ab, s_ac, s_bc;
      s_ab           = wn_ff > 0;
      s_ac           = an_ff > 0;
      s_bc           = bc_ff > 0;
      tag4_in.in_tri = (s_ac != s_ab) && (s_bc == s_ab);
      tag4_in.degen  = (dd_ff == '0);
      tag4_in.neg_v  = s_ac != dd_ff[CROSS_W-1];
      tag4_in.neg_w  = wn_ff[CROSS_W-1] != dd_ff[CROSS_W-1];
   end

   // half the divisor is added so the truncating divider rounds to nearest
   always_comb begin
      div_in.rem_v = '0;
      div_in.rem_w = '0;
      div_in.quo_v = (NUM_W'(mag_v_ff) << COORD_FRAC_BITS) + NUM_W'(mag_d_ff >> 1);
      div_in.quo_w = (NUM_W'(mag_w_ff) << COORD_FRAC_BITS) + NUM_W'(mag_d_ff >> 1);
      div_in.den   = mag_d_ff;
      div_in.tag   = tag4_ff;
   end

   assign out_valid = valid_ff[FRONT_STAGES-1];
   assign out_data  = div_ff;

endmodule

// ----- rtl/tbt_div_cell.sv -----
// one restoring division step for both weight lanes
`timescale 1ns / 1ps
module tbt_div_cell
   import tbt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  div_type in_data,
   output logic    out_valid,
   output div_type out_data
);

   logic    valid_ff;
   div_type data_ff, data_in;

   always_comb begin
      logic [MAG_W:0] t_v, t_w, dif_v, dif_w;
      t_v   = {in_data.rem_v, in_data.quo_v[NUM_W-1]};
      t_w   = {in_data.rem_w, in_data.quo_w[NUM_W-1]};
      dif_v = t_v - {1'b0, in_data.den};
      dif_w = t_w - {1'b0, in_data.den};
      data_in       = in_data;
      // top bit of the difference is the borrow
      data_in.rem_v = dif_v[MAG_W] ? t_v[MAG_W-1:0] : dif_v[MAG_W-1:0];
      data_in.rem_w = dif_w[MAG_W] ? t_w[MAG_W-1:0] : dif_w[MAG_W-1:0];
      data_in.quo_v = {in_data.quo_v[NUM_W-2:0], ~dif_v[MAG_W]};
      data_in.quo_w = {in_data.quo_w[NUM_W-2:0], ~dif_w[MAG_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/tbt_back.sv -----
// sign restore, third weight and saturation
`timescale 1ns / 1ps
module tbt_back
   import tbt_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  div_type                    in_data,
   output logic                       out_valid,
   output logic                       inside_res,
   output logic                       degenerate,
   output logic signed [WEIGHT_W-1:0] weight_u,
   output logic signed [WEIGHT_W-1:0] weight_v,
   output logic signed [WEIGHT_W-1:0] weight_w
);

   localparam logic signed [U_W-1:0] SAT_HI  = U_W'((1 << (WEIGHT_W - 1)) - 1);
   localparam logic signed [U_W-1:0] SAT_LO  = ~SAT_HI;
   localparam logic signed [U_W-1:0] ONE_VAL = U_W'(1) << COORD_FRAC_BITS;

   function automatic logic signed [WEIGHT_W-1:0] sat_weight(
      input logic signed [U_W-1:0] x
   );
      logic signed [U_W-1:0] y;
      y = x;
      if (x > SAT_HI) y = SAT_HI;
      if (x < SAT_LO) y = SAT_LO;
      return y[WEIGHT_W-1:0];
   endfunction

   logic                     valid_a_ff, valid_b_ff;
   logic signed [SGN_W-1:0]  v_ff, w_ff;
   tag_type                  tag_ff;
   logic                     inside_ff, degen_ff;
   logic signed [WEIGHT_W-1:0] wu_ff, wv_ff, ww_ff;
   logic signed [U_W-1:0]    u_full, v_full, w_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   assign v_full = U_W'(v_ff);
   assign w_full = U_W'(w_ff);
   assign u_full = ONE_VAL - v_full - w_full;

   always_ff @(posedge clock) begin
      v_ff      <= in_data.tag.neg_v ? -$signed({1'b0, in_data.quo_v})
                                     : $signed({1'b0, in_data.quo_v});
      w_ff      <= in_data.tag.neg_w ? -$signed({1'b0, in_data.quo_w})
                                     : $signed({1'b0, in_data.quo_w});
      tag_ff    <= in_data.tag;
      inside_ff <= tag_ff.in_tri;
      degen_ff  <= tag_ff.degen;
      wu_ff     <= tag_ff.degen ? '0 : sat_weight(u_full);
      wv_ff     <= tag_ff.degen ? '0 : sat_weight(v_full);
      ww_ff     <= tag_ff.degen ? '0 : sat_weight(w_full);
   end

   assign out_valid  = valid_b_ff;
   assign inside_res = inside_ff;
   assign degenerate = degen_ff;
   assign weight_u   = wu_ff;
   assign weight_v   = wv_ff;
   assign weight_w   = ww_ff;

endmodule

// ----- rtl/triangle_barycentric_test_core.sv -----
// top level of the point-in-triangle test with barycentric weights
`timescale 1ns / 1ps
// usage
//   request: drive req_* with a point and three vertices and raise start; the
//   transfer happens on a rising edge with start high and busy low. busy is
//   only high during reset, so a new request can be taken every cycle.
//   response: rsp_valid is high for one cycle with rsp_inside_res,
//   rsp_degenerate and the three weights; the receiver cannot hold it off.
// pipeline and throughput
//   5 front stages, one cell per quotient bit of the 53-bit rounded
//   dividend, 2 back stages; one item per cycle.
//   the depth is set by the chain of restoring division cells, each of
//   which resolves one quotient bit of both weights per cycle.
// reset
//   synchronous, active high; drops every item in flight. no state is kept
//   between items, so nothing else needs clearing.
// stalls
//   none: responses leave in order, exactly one per accepted request.
module triangle_barycentric_test_core
   import tbt_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [COORD_W-1:0]  req_point_u,
   input  logic signed [COORD_W-1:0]  req_point_v,
   input  logic signed [COORD_W-1:0]  req_vert_a_u,
   input  logic signed [COORD_W-1:0]  req_vert_a_v,
   input  logic signed [COORD_W-1:0]  req_vert_b_u,
   input  logic signed [COORD_W-1:0]  req_vert_b_v,
   input  logic signed [COORD_W-1:0]  req_vert_c_u,
   input  logic signed [COORD_W-1:0]  req_vert_c_v,
   output logic                       rsp_valid,
   output logic                       rsp_inside_res,
   output logic                       rsp_degenerate,
   output logic signed [WEIGHT_W-1:0] rsp_weight_u,
   output logic signed [WEIGHT_W-1:0] rsp_weight_v,
   output logic signed [WEIGHT_W-1:0] rsp_weight_w
);

   logic    chain_valid [0:NUM_W];
   div_type chain_data  [0:NUM_W];

   assign busy = reset;

   tbt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .point_u   (req_point_u),
      .point_v   (req_point_v),
      .vert_a_u  (req_vert_a_u),
      .vert_a_v  (req_vert_a_v),
      .vert_b_u  (req_vert_b_u),
      .vert_b_v  (req_vert_b_v),
      .vert_c_u  (req_vert_c_u),
      .vert_c_v  (req_vert_c_v),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      tbt_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   tbt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[NUM_W]),
      .in_data    (chain_data[NUM_W]),
      .out_valid  (rsp_valid),
      .inside_res (rsp_inside_res),
      .degenerate (rsp_degenerate),
      .weight_u   (rsp_weight_u),
      .weight_v   (rsp_weight_v),
      .weight_w   (rsp_weight_w)
   );

endmodule

// ----- rtl/tbt_checker.sv -----
// port-level checks for the triangle barycentric test core
`timescale 1ns / 1ps
module tbt_checker
   import tbt_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic                       rsp_valid,
   input  logic                       rsp_inside_res,
   input  logic                       rsp_degenerate,
   input  logic signed [WEIGHT_W-1:0] rsp_weight_u,
   input  logic signed [WEIGHT_W-1:0] rsp_weight_v,
   input  logic signed [WEIGHT_W-1:0] rsp_weight_w
);

   // every response traces back to a request a fixed latency earlier
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without matching request");

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_weight_u == '0 && rsp_weight_v == '0 && rsp_weight_w == '0)
      else $error("degenerate triangle with nonzero weights");

   // a flat triangle has no strict interior
   a_degen_outside : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> !rsp_inside_res)
      else $error("inside reported for a degenerate triangle");

   a_inside_weights : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |->
         !rsp_weight_u[WEIGHT_W-1] && !rsp_weight_v[WEIGHT_W-1]
         && !rsp_weight_w[WEIGHT_W-1])
      else $error("negative weight for an inside point");

endmodule

bind triangle_barycentric_test_core tbt_checker u_tbt_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_inside_res (rsp_inside_res),
   .rsp_degenerate (rsp_degenerate),
   .rsp_weight_u   (rsp_weight_u),
   .rsp_weight_v   (rsp_weight_v),
   .rsp_weight_w   (rsp_weight_w)
);
